// ===== hdl/box_rotate_scale_clip_defines.svh =====
// ----------------------------------------------------------------------------
// Box rotate/scale/clip assertion macros
// Shared property shorthands; each expects clk and rst in the calling scope.
// ----------------------------------------------------------------------------
`ifndef BOX_ROTATE_SCALE_CLIP_DEFINES_SVH
`define BOX_ROTATE_SCALE_CLIP_DEFINES_SVH

// same-cycle implication
`define BRSC_ASSERT_IMPL(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication
`define BRSC_ASSERT_NEXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== hdl/brsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Box rotate/scale/clip package
// Widths, register indexes, codes and shared types.
// ----------------------------------------------------------------------------
package brsc_pkg;

  localparam int FRAC_BITS = 4;
  localparam int MAX_BOXES = 32;

  localparam int SIZE_W  = 12;
  localparam int LIM_W   = SIZE_W + FRAC_BITS;
  localparam int IN_W    = 18;
  localparam int SUM_W   = IN_W + 1;
  localparam int COORD_W = ((LIM_W > SUM_W) ? LIM_W : SUM_W) + 2;
  localparam int NUM_W   = LIM_W + SIZE_W + 2;
  localparam int CNT_W   = 6;
  localparam int ROT_W   = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SIZE_W;
  localparam int IN_DATA_W  = 4 * IN_W;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 4 * SIZE_W;

  localparam int TUSER_SCORE = 0;
  localparam int TUSER_START = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROTATION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd4;

  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  localparam logic KIND_RECT  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [SIZE_W-1:0] RST_SRC_WIDTH  = 12'd256;
  localparam logic [SIZE_W-1:0] RST_SRC_HEIGHT = 12'd256;
  localparam logic [SIZE_W-1:0] RST_DST_WIDTH  = 12'd320;
  localparam logic [SIZE_W-1:0] RST_DST_HEIGHT = 12'd240;

  typedef struct packed {
    logic busy;
    logic done;
  } map_stat_t;

endpackage

// ===== hdl/brsc_map.sv =====
// ----------------------------------------------------------------------------
// Coordinate mapper
// Computes round(v * dst / lim) half up, capped at dst - 1, with a
// multiply step followed by a restoring shift-subtract divider.
// ----------------------------------------------------------------------------
module brsc_map (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [brsc_pkg::LIM_W-1:0]    v,
  input  logic [brsc_pkg::LIM_W-1:0]    lim,
  input  logic [brsc_pkg::SIZE_W-1:0]   dst,
  output logic [brsc_pkg::SIZE_W-1:0]   q,
  output brsc_pkg::map_stat_t           stat
);
  import brsc_pkg::*;

  localparam int BIT_W = $clog2(SIZE_W);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_CAP} mstate_t;

  mstate_t                 mstate;
  logic [LIM_W-1:0]        v_r;
  logic [LIM_W-1:0]        lim_r;
  logic [SIZE_W-1:0]       dst_r;
  logic [NUM_W-1:0]        rem;
  logic [NUM_W-1:0]        dsh;
  logic [BIT_W-1:0]        bit_cnt;
  logic                    done_r;
  logic [LIM_W+SIZE_W:0]   prod;

  assign prod = (LIM_W+SIZE_W+1)'({v_r, 1'b0}) * (LIM_W+SIZE_W+1)'(dst_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= M_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (mstate)
        M_IDLE: begin
          if (start) begin
            v_r    <= v;
            lim_r  <= lim;
            dst_r  <= dst;
            mstate <= M_MUL;
          end
        end
        M_MUL: begin
          // numerator 2*v*dst + lim over divisor 2*lim, aligned to the top quotient bit
          rem     <= NUM_W'(prod) + NUM_W'(lim_r);
          dsh     <= NUM_W'({lim_r, 1'b0}) << (SIZE_W - 1);
          q       <= '0;
          bit_cnt <= BIT_W'(SIZE_W - 1);
          mstate  <= M_DIV;
        end
        M_DIV: begin
          if (rem >= dsh) begin
            rem        <= rem - dsh;
            q[bit_cnt] <= 1'b1;
          end
          dsh <= dsh >> 1;
          if (bit_cnt == '0) begin
            mstate <= M_CAP;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        M_CAP: begin
          if (q >= dst_r) begin
            q <= dst_r - 1'b1;
          end
          done_r <= 1'b1;
          mstate <= M_IDLE;
        end
        default: mstate <= M_IDLE;
      endcase
    end
  end

  assign stat = '{busy: (mstate != M_IDLE), done: done_r};

endmodule

// ===== hdl/box_rotate_scale_clip.sv =====
// ----------------------------------------------------------------------------
// Box rotate/scale/clip
// Maps detection boxes from the source canvas onto the destination canvas:
// quarter-turn rotation, exact rational scaling, ordering, clamping and
// half-up rounding, with per-frame clear and box-count handling.
//
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: box_left, box_top, box_span_x, box_span_y
//                tuser: score_positive, frame_start
// m_axis    out  tdata: corner_x_min, corner_y_min, corner_x_max, corner_y_max
//                tuser: result_kind
// cfg       in   cfg_index selects rotation, source/target width/height
//
// A drawn box passes through corner sum, rotate and clamp steps, then the
// shared mapper runs four times (start, one multiply, 12 divide steps, cap,
// done) and a final step loads the output. A clear result goes straight
// to the output step, and a dropped box leaves the block idle.
// s_axis_tready is high only while no box is in work; a held output does
// not block acceptance, but a finished box waits until the output is free.
// rst is synchronous and restores the register defaults and frame state.
// ----------------------------------------------------------------------------
`include "box_rotate_scale_clip_defines.svh"

module box_rotate_scale_clip (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [brsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [brsc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // box_left, box_top, box_span_x, box_span_y
  input  logic [brsc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // score_positive, frame_start
  input  logic [brsc_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // corner_x_min, corner_y_min, corner_x_max, corner_y_max
  output logic [brsc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // result_kind
  output logic [0:0]                         m_axis_tuser
);
  import brsc_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [LIM_W-1:0]          lim_t;

  typedef enum logic [2:0] {ST_IDLE, ST_ROTATE, ST_CLAMP, ST_MAP, ST_DONE} state_t;

  // configuration
  logic [ROT_W-1:0]  rotation;
  logic [SIZE_W-1:0] src_w;
  logic [SIZE_W-1:0] src_h;
  logic [SIZE_W-1:0] dst_w;
  logic [SIZE_W-1:0] dst_h;

  // frame and sequencer state
  state_t            state;
  logic              frame_suppressed;
  logic [CNT_W-1:0]  boxes_in_frame;
  logic [1:0]        idx;
  logic              map_start;
  logic              kind;
  coord_t            bx0, by0, bx1, by1;
  lim_t              cv [4];
  logic [SIZE_W-1:0] res [4];
  logic              out_valid;
  logic              out_kind;
  logic [OUT_DATA_W-1:0] out_data;

  // accept decode
  logic              accept;
  logic              in_start;
  logic              in_score;
  logic              sizes_ok;
  logic              supp_eff;
  logic [CNT_W-1:0]  cnt_eff;
  logic              take_box;
  coord_t            in_left, in_top, in_right, in_bottom;

  // geometry
  coord_t            sw_s, sh_s;
  coord_t            rot_ax, rot_ay, rot_bx, rot_by;
  coord_t            x_lo, x_hi, y_lo, y_hi;
  lim_t              lim_x, lim_y;

  // mapper
  lim_t              map_v;
  lim_t              map_lim;
  logic [SIZE_W-1:0] map_dst;
  logic [SIZE_W-1:0] map_q;
  map_stat_t         map_stat;

  function automatic lim_t clamp_coord(coord_t c, lim_t lim);
    if (c < 0) begin
      return '0;
    end else if (c > coord_t'(lim)) begin
      return lim;
    end
    return lim_t'(c);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= ROT_0;
      src_w    <= RST_SRC_WIDTH;
      src_h    <= RST_SRC_HEIGHT;
      dst_w    <= RST_DST_WIDTH;
      dst_h    <= RST_DST_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROTATION:   rotation <= cfg_data[ROT_W-1:0];
        REG_SRC_WIDTH:  src_w    <= cfg_data;
        REG_SRC_HEIGHT: src_h    <= cfg_data;
        REG_DST_WIDTH:  dst_w    <= cfg_data;
        REG_DST_HEIGHT: dst_h    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_start      = s_axis_tuser[TUSER_START];
  assign in_score      = s_axis_tuser[TUSER_SCORE];
  assign sizes_ok      = (src_w != '0) && (src_h != '0) && (dst_w != '0) && (dst_h != '0);
  assign supp_eff      = in_start ? 1'b0 : frame_suppressed;
  assign cnt_eff       = in_start ? '0 : boxes_in_frame;
  assign take_box      = !supp_eff && (cnt_eff < CNT_W'(MAX_BOXES));

  assign in_left   = coord_t'($signed(s_axis_tdata[IN_W-1:0]));
  assign in_top    = coord_t'($signed(s_axis_tdata[2*IN_W-1:IN_W]));
  assign in_right  = in_left + coord_t'($signed(s_axis_tdata[3*IN_W-1:2*IN_W]));
  assign in_bottom = in_top + coord_t'($signed(s_axis_tdata[4*IN_W-1:3*IN_W]));

  assign sw_s = coord_t'(src_w) << FRAC_BITS;
  assign sh_s = coord_t'(src_h) << FRAC_BITS;

  always_comb begin
    case (rotation)
      ROT_90: begin
        rot_ax = sh_s - by0;  rot_ay = bx0;
        rot_bx = sh_s - by1;  rot_by = bx1;
      end
      ROT_180: begin
        rot_ax = sw_s - bx0;  rot_ay = sh_s - by0;
        rot_bx = sw_s - bx1;  rot_by = sh_s - by1;
      end
      ROT_270: begin
        rot_ax = by0;  rot_ay = sw_s - bx0;
        rot_bx = by1;  rot_by = sw_s - bx1;
      end
      default: begin
        rot_ax = bx0;  rot_ay = by0;
        rot_bx = bx1;  rot_by = by1;
      end
    endcase
  end

  // odd quarter turns swap the source axes
  assign lim_x = lim_t'(rotation[0] ? src_h : src_w) << FRAC_BITS;
  assign lim_y = lim_t'(rotation[0] ? src_w : src_h) << FRAC_BITS;

  assign x_lo = (bx0 > bx1) ? bx1 : bx0;
  assign x_hi = (bx0 > bx1) ? bx0 : bx1;
  assign y_lo = (by0 > by1) ? by1 : by0;
  assign y_hi = (by0 > by1) ? by0 : by1;

  // odd index is a y coordinate
  assign map_v   = cv[idx];
  assign map_lim = idx[0] ? lim_y : lim_x;
  assign map_dst = idx[0] ? dst_h : dst_w;

  brsc_map u_map (
    .clk   (clk),
    .rst   (rst),
    .start (map_start),
    .v     (map_v),
    .lim   (map_lim),
    .dst   (map_dst),
    .q     (map_q),
    .stat  (map_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      frame_suppressed <= 1'b0;
      boxes_in_frame   <= '0;
      map_start        <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      map_start <= 1'b0;
      if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            bx0 <= in_left;
            by0 <= in_top;
            bx1 <= in_right;
            by1 <= in_bottom;
            for (int i = 0; i < 4; i++) begin
              res[i] <= '0;
            end
            if (in_start && !in_score) begin
              frame_suppressed <= 1'b1;
              boxes_in_frame   <= '0;
              kind             <= KIND_CLEAR;
              if (sizes_ok) begin
                state <= ST_DONE;
              end
            end else begin
              if (in_start) begin
                frame_suppressed <= 1'b0;
                boxes_in_frame   <= '0;
              end
              kind <= KIND_RECT;
              if (take_box) begin
                boxes_in_frame <= cnt_eff + 1'b1;
                if (sizes_ok) begin
                  state <= ST_ROTATE;
                end
              end
            end
          end
        end
        ST_ROTATE: begin
          bx0   <= rot_ax;
          by0   <= rot_ay;
          bx1   <= rot_bx;
          by1   <= rot_by;
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          cv[0]     <= clamp_coord(x_lo, lim_x);
          cv[1]     <= clamp_coord(y_lo, lim_y);
          cv[2]     <= clamp_coord(x_hi, lim_x);
          cv[3]     <= clamp_coord(y_hi, lim_y);
          idx       <= '0;
          map_start <= 1'b1;
          state     <= ST_MAP;
        end
        ST_MAP: begin
          if (map_stat.done) begin
            res[idx] <= map_q;
            if (idx == 2'd3) begin
              state <= ST_DONE;
            end else begin
              idx       <= idx + 1'b1;
              map_start <= 1'b1;
            end
          end
        end
        ST_DONE: begin
          // hold the finished box until the output register frees up
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_kind  <= kind;
            out_data  <= {res[3], res[2], res[1], res[0]};
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_data;
  assign m_axis_tuser[0] = out_kind;

  `BRSC_ASSERT_NEXT(a_one_box_at_a_time, accept && take_box && sizes_ok, !s_axis_tready, "box accepted while busy")
  `BRSC_ASSERT_NEXT(a_clear_suppresses, accept && in_start && !in_score, frame_suppressed, "clear frame not suppressed")
  `BRSC_ASSERT_IMPL(a_done_in_map, map_stat.done, state == ST_MAP, "mapper finished outside map phase")
  `BRSC_ASSERT_IMPL(a_map_idle, state == ST_IDLE, !map_stat.busy, "mapper busy while idle")
  `BRSC_ASSERT_NEXT(a_clear_zero, state == ST_DONE && kind == KIND_CLEAR && (!out_valid || m_axis_tready), m_axis_tvalid && m_axis_tdata == '0, "clear result carries corners")

endmodule

// ===== bench/box_rotate_scale_clip_tb.sv =====
// ----------------------------------------------------------------------------
// Box rotate/scale/clip testbench
// Streams detection boxes through the mapper under a range of rotations and
// canvas sizes, predicts every corner result in a local model of the mapping
// and frame rules, and compares each output beat field by field.
// ----------------------------------------------------------------------------
module box_rotate_scale_clip_tb;
  import brsc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [IN_W-1:0] left;
    logic [IN_W-1:0] top;
    logic [IN_W-1:0] span_x;
    logic [IN_W-1:0] span_y;
    logic            score;
    logic            start;
  } box_t;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] x_min;
    logic [SIZE_W-1:0] y_min;
    logic [SIZE_W-1:0] x_max;
    logic [SIZE_W-1:0] y_max;
  } corners_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_valid = 1'b0;
  logic [IN_DATA_W-1:0]  s_data = '0;
  logic [IN_USER_W-1:0]  s_user = '0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  box_rotate_scale_clip uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mapper copy: registers and frame state
  logic [ROT_W-1:0]  cur_rot = ROT_0;
  logic [SIZE_W-1:0] cur_sw = RST_SRC_WIDTH;
  logic [SIZE_W-1:0] cur_sh = RST_SRC_HEIGHT;
  logic [SIZE_W-1:0] cur_tw = RST_DST_WIDTH;
  logic [SIZE_W-1:0] cur_th = RST_DST_HEIGHT;
  logic              frame_dropped = 1'b0;
  logic [CNT_W-1:0]  frame_boxes = '0;

  corners_t pending_corners[$];
  box_t     dir_box[$];
  bit       dir_typed[$];
  corners_t dir_corners[$];

  int  errors = 0;
  int  boxes_sent = 0;
  int  results_due = 0;
  int  results_seen = 0;
  int  clears_seen = 0;
  int  settings_run = 0;
  int  cycle_count = 0;
  bit  gaps_on = 1'b1;

  corners_t got, want;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, pending_corners.size());
    $display("tb: failure");
    $finish;
  end

  // clamp to [0, span], scale by dst/span, round half up, cap at dst - 1
  function automatic logic [SIZE_W-1:0] scale_coord(input longint v, input longint span,
                                                    input longint dst);
    longint lim, q;
    lim = span << FRAC_BITS;
    if (v < 0) v = 0;
    if (v > lim) v = lim;
    q = (2 * v * dst + lim) / (2 * lim);
    if (q >= dst) q = dst - 1;
    return q[SIZE_W-1:0];
  endfunction

  function automatic void turn_point(input longint x, input longint y,
                                     output longint rx, output longint ry);
    longint sw16, sh16;
    sw16 = longint'(cur_sw) << FRAC_BITS;
    sh16 = longint'(cur_sh) << FRAC_BITS;
    case (cur_rot)
      ROT_90: begin
        rx = sh16 - y;
        ry = x;
      end
      ROT_180: begin
        rx = sw16 - x;
        ry = sh16 - y;
      end
      ROT_270: begin
        rx = y;
        ry = sw16 - x;
      end
      default: begin
        rx = x;
        ry = y;
      end
    endcase
  endfunction

  // returns 1 when the box yields a result; advances the frame state
  function automatic bit map_box(input box_t b, output corners_t r);
    longint x0, y0, x1, y1, ax, ay, bx, by, t, rw, rh;
    bit sizes_ok;
    sizes_ok = cur_sw != 0 && cur_sh != 0 && cur_tw != 0 && cur_th != 0;
    r = '0;
    if (b.start) begin
      frame_dropped = 1'b0;
      frame_boxes = '0;
      if (!b.score) begin
        frame_dropped = 1'b1;
        if (!sizes_ok) return 1'b0;
        r.kind = KIND_CLEAR;
        return 1'b1;
      end
    end
    if (frame_dropped) return 1'b0;
    if (frame_boxes >= MAX_BOXES) return 1'b0;
    frame_boxes = frame_boxes + 1'b1;
    if (!sizes_ok) return 1'b0;
    x0 = longint'($signed(b.left));
    y0 = longint'($signed(b.top));
    x1 = x0 + longint'($signed(b.span_x));
    y1 = y0 + longint'($signed(b.span_y));
    turn_point(x0, y0, ax, ay);
    turn_point(x1, y1, bx, by);
    if (ax > bx) begin
      t = ax;
      ax = bx;
      bx = t;
    end
    if (ay > by) begin
      t = ay;
      ay = by;
      by = t;
    end
    if (cur_rot[0]) begin
      rw = longint'(cur_sh);
      rh = longint'(cur_sw);
    end else begin
      rw = longint'(cur_sw);
      rh = longint'(cur_sh);
    end
    r.kind  = KIND_RECT;
    r.x_min = scale_coord(ax, rw, longint'(cur_tw));
    r.y_min = scale_coord(ay, rh, longint'(cur_th));
    r.x_max = scale_coord(bx, rw, longint'(cur_tw));
    r.y_max = scale_coord(by, rh, longint'(cur_th));
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [SIZE_W-1:0] exp_v,
                             input logic [SIZE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // output side: check each beat, then pick the next ready, at random while gaps are on
  always @(posedge clk) begin
    if (rst) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_ready) begin
        got.kind  = m_axis_tuser[0];
        got.x_min = m_axis_tdata[SIZE_W-1:0];
        got.y_min = m_axis_tdata[2*SIZE_W-1:SIZE_W];
        got.x_max = m_axis_tdata[3*SIZE_W-1:2*SIZE_W];
        got.y_max = m_axis_tdata[4*SIZE_W-1:3*SIZE_W];
        if (pending_corners.size() == 0) begin
          $display("%0t: unexpected beat, expected none actual kind %0d corners %0d %0d %0d %0d",
                   $time, got.kind, got.x_min, got.y_min, got.x_max, got.y_max);
          errors++;
        end else begin
          want = pending_corners.pop_front();
          check_field("result_kind", {11'd0, want.kind}, {11'd0, got.kind});
          check_field("corner_x_min", want.x_min, got.x_min);
          check_field("corner_y_min", want.y_min, got.y_min);
          check_field("corner_x_max", want.x_max, got.x_max);
          check_field("corner_y_max", want.y_max, got.y_max);
        end
        results_seen++;
        if (got.kind == KIND_CLEAR) clears_seen++;
      end
      m_ready <= !gaps_on || ($urandom_range(0, 99) >= 12);
    end
  end

  // present one box, hold it until accepted, then predict its result
  task automatic drive_box(input box_t b, input bit typed, input corners_t given);
    logic [IN_USER_W-1:0] u;
    corners_t r;
    while (gaps_on && $urandom_range(0, 99) < 12) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    u = '0;
    u[TUSER_SCORE] = b.score;
    u[TUSER_START] = b.start;
    s_valid <= 1'b1;
    s_data  <= {b.span_y, b.span_x, b.top, b.left};
    s_user  <= u;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    boxes_sent++;
    if (map_box(b, r)) begin
      pending_corners.push_back(typed ? given : r);
      results_due++;
    end
  endtask

  // stop sending, let every result arrive, then cover a dropped box in work
  task automatic wait_idle();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending_corners.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_ROTATION:   cur_rot = val[ROT_W-1:0];
      REG_SRC_WIDTH:  cur_sw = val;
      REG_SRC_HEIGHT: cur_sh = val;
      REG_DST_WIDTH:  cur_tw = val;
      REG_DST_HEIGHT: cur_th = val;
      default: ;
    endcase
  endtask

  task automatic random_box(output box_t b);
    logic [31:0] rnd;
    int tmp, sx16, sy16;
    b = '0;
    if ($urandom_range(0, 99) < 15) begin
      rnd = $urandom;
      b.left = rnd[IN_W-1:0];
      rnd = $urandom;
      b.top = rnd[IN_W-1:0];
      rnd = $urandom;
      b.span_x = rnd[IN_W-1:0];
      rnd = $urandom;
      b.span_y = rnd[IN_W-1:0];
    end else begin
      // mostly inside the source canvas, with a margin past each edge
      sx16 = int'(cur_sw) * 16;
      sy16 = int'(cur_sh) * 16;
      tmp = int'($urandom_range(0, sx16 + 64)) - 32;
      b.left = tmp[IN_W-1:0];
      tmp = int'($urandom_range(0, sy16 + 64)) - 32;
      b.top = tmp[IN_W-1:0];
      tmp = int'($urandom_range(0, sx16 / 2 + 32)) - 16;
      b.span_x = tmp[IN_W-1:0];
      tmp = int'($urandom_range(0, sy16 / 2 + 32)) - 16;
      b.span_y = tmp[IN_W-1:0];
    end
  endtask

  // frames of random length, some past the box limit, with a little noise
  task automatic run_setting(input logic [ROT_W-1:0] rot, input logic [SIZE_W-1:0] sw,
                             input logic [SIZE_W-1:0] sh, input logic [SIZE_W-1:0] tw,
                             input logic [SIZE_W-1:0] th, input int target, input int hold_at);
    int made0, taken, frame_left;
    bit first;
    box_t b;
    wait_idle();
    write_reg(REG_ROTATION, {10'd0, rot});
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, tw);
    write_reg(REG_DST_HEIGHT, th);
    cfg_wr_en <= 1'b0;
    settings_run++;
    made0 = results_due;
    taken = 0;
    frame_left = 0;
    while (results_due - made0 < target && taken < 2 * target) begin
      first = (frame_left == 0);
      if (first) frame_left = $urandom_range(1, 40);
      random_box(b);
      b.start = first ? ($urandom_range(0, 99) < 95) : ($urandom_range(0, 99) < 3);
      b.score = first ? ($urandom_range(0, 99) < 88) : 1'($urandom_range(0, 1));
      drive_box(b, 1'b0, '0);
      frame_left--;
      taken++;
      if (taken == hold_at) wait_idle();
    end
  endtask

  task automatic add_row(input logic [IN_W-1:0] l, input logic [IN_W-1:0] t,
                         input logic [IN_W-1:0] sx, input logic [IN_W-1:0] sy,
                         input bit score, input bit start, input bit typed,
                         input logic kind, input logic [SIZE_W-1:0] x0,
                         input logic [SIZE_W-1:0] y0, input logic [SIZE_W-1:0] x1,
                         input logic [SIZE_W-1:0] y1);
    box_t b;
    corners_t c;
    b.left = l;
    b.top = t;
    b.span_x = sx;
    b.span_y = sy;
    b.score = score;
    b.start = start;
    c.kind = kind;
    c.x_min = x0;
    c.y_min = y0;
    c.x_max = x1;
    c.y_max = y1;
    dir_box.push_back(b);
    dir_typed.push_back(typed);
    dir_corners.push_back(c);
  endtask

  initial begin
    // directed rows at the reset setting: 256x256 source onto 320x240
    // no frame start yet: open frame, score ignored
    add_row(18'h00000, 18'h00000, 18'h00000, 18'h00000, 0, 0, 1, KIND_RECT, 0, 0, 0, 0);
    // first box with non-positive score: clear, then the frame is dropped
    add_row(18'h00100, 18'h00100, 18'h00100, 18'h00100, 0, 1, 1, KIND_CLEAR, 0, 0, 0, 0);
    add_row(18'h00100, 18'h00100, 18'h00100, 18'h00100, 1, 0, 0, KIND_RECT, 0, 0, 0, 0);
    // full canvas: maxima capped at target - 1
    add_row(18'h00000, 18'h00000, 18'h01000, 18'h01000, 1, 1, 1, KIND_RECT, 0, 0, 319, 239);
    // largest positive values: everything clamps to the canvas edge
    add_row(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 1, 0, 1, KIND_RECT, 319, 239, 319, 239);
    // most negative values: everything clamps to zero
    add_row(18'h20000, 18'h20000, 18'h20000, 18'h20000, 1, 0, 1, KIND_RECT, 0, 0, 0, 0);
    // negative spans: corners swap
    add_row(18'h01000, 18'h01000, 18'h3F000, 18'h3F000, 1, 0, 1, KIND_RECT, 0, 0, 319, 239);
    add_row(18'h00000, 18'h1FFFF, 18'h1FFFF, 18'h20000, 1, 0, 1, KIND_RECT, 0, 0, 319, 239);
    // half-pixel points for rounding
    add_row(18'h00020, 18'h00022, 18'h00040, 18'h00011, 1, 0, 0, KIND_RECT, 0, 0, 0, 0);
    add_row(18'h00033, 18'h00088, 18'h00007, 18'h00001, 1, 0, 0, KIND_RECT, 0, 0, 0, 0);
    // later box with non-positive score is still drawn
    add_row(18'h00064, 18'h000C8, 18'h0012C, 18'h00190, 0, 0, 0, KIND_RECT, 0, 0, 0, 0);
    add_row(18'h2AAAA, 18'h15555, 18'h2AAAA, 18'h15555, 1, 0, 0, KIND_RECT, 0, 0, 0, 0);
    add_row(18'h15555, 18'h2AAAA, 18'h15555, 18'h2AAAA, 0, 0, 0, KIND_RECT, 0, 0, 0, 0);
    add_row(18'h00FFF, 18'h00FF0, 18'h0000F, 18'h3FFF1, 1, 1, 0, KIND_RECT, 0, 0, 0, 0);
    add_row(18'h00800, 18'h00800, 18'h00321, 18'h3FA00, 1, 0, 0, KIND_RECT, 0, 0, 0, 0);
    add_row(18'h3FFFF, 18'h00001, 18'h00002, 18'h3FFFE, 1, 0, 0, KIND_RECT, 0, 0, 0, 0);
    add_row(18'h00400, 18'h00C00, 18'h00400, 18'h00400, 1, 1, 0, KIND_RECT, 0, 0, 0, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < dir_box.size(); i++)
      drive_box(dir_box[i], dir_typed[i], dir_corners[i]);

    run_setting(ROT_90, 12'd640, 12'd480, 12'd320, 12'd240, 52, 0);
    run_setting(ROT_180, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 52, 0);
    run_setting(ROT_270, 12'd1, 12'd1, 12'd1, 12'd1, 52, 0);
    run_setting(ROT_0, 12'd1, 12'd4095, 12'd4095, 12'd1, 52, 0);
    // hold the sender mid-stream until the output has drained
    run_setting(ROT_90, 12'd100, 12'd37, 12'd1920, 12'd1080, 52, 25);
    // a zero size register: boxes count but give nothing
    run_setting(ROT_180, 12'd256, 12'd256, 12'd0, 12'd240, 20, 0);
    run_setting(ROT_270, 12'd0, 12'd256, 12'd320, 12'd240, 20, 0);
    for (int p = 0; p < 5; p++) begin
      gaps_on = (p != 2);
      run_setting(ROT_W'($urandom_range(0, 3)), SIZE_W'($urandom_range(1, 4095)),
                  SIZE_W'($urandom_range(1, 4095)), SIZE_W'($urandom_range(1, 4095)),
                  SIZE_W'($urandom_range(1, 4095)), 52, 0);
    end
    gaps_on = 1'b1;

    wait_idle();
    $display("tb: %0d boxes sent over %0d register settings, all four rotations", boxes_sent,
             settings_run + 1);
    $display("tb: %0d results checked, %0d of them clear results", results_seen, clears_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
